FILE: src/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4,
      OP_CLEAR = 3'd5
   } op_type;

   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_LIMIT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_PULSE = 2'd2;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
   localparam logic [7:0]  POLL_LIMIT_RESET  = 8'd10;
   localparam logic [3:0]  CLEAR_PULSE_RESET = 4'd9;

   typedef struct packed {
      logic [15:0] half_period_ticks;
      logic [7:0]  ack_poll_limit;
      logic [3:0]  clear_pulses;
   } cfg_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_missing;
   } rsp_type;

endpackage

FILE: src/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Bus sequencer: command state, segment timing and pin levels; one tick per
// advance, result word of that tick presented combinationally.
// ----------------------------------------------------------------------------
module i2cm_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [2:0]        op,
   input  logic [7:0]        tx_byte,
   input  logic              send_ack,
   input  logic              sda_sample,
   input  i2cm_pkg::cfg_type cfg,
   output i2cm_pkg::rsp_type rsp
);

   typedef struct packed {
      logic scl;
      logic sda;
   } pins_type;

   function automatic pins_type start_pins(input logic [3:0] k, input pins_type p);
      pins_type r;
      r = p;
      if (k == 4'd0) begin
         r.scl = 1'b1;
      end else if (k == 4'd1) begin
         r.sda = 1'b0;
      end else begin
         r.scl = 1'b0;
      end
      return r;
   endfunction

   function automatic pins_type stop_pins(input logic [3:0] k, input pins_type p);
      pins_type r;
      r = p;
      if (k == 4'd0) begin
         r.scl = 1'b0;
      end else if (k == 4'd1) begin
         r.sda = 1'b0;
         r.scl = 1'b1;
      end else begin
         r.sda = 1'b1;
      end
      return r;
   endfunction

   i2cm_pkg::op_type op_ff, op_in;
   logic [3:0]  step_ff, step_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  poll_ff, poll_in;
   pins_type    pins_ff, pins_in;
   logic        ack_ff, ack_in;
   logic [7:0]  rx_ff, rx_in;
   logic        choice_ff, choice_in;
   logic        done;
   logic        op_valid;

   logic [15:0] hp;
   logic [7:0]  poll_lim;
   logic [3:0]  clear_lim;

   assign hp        = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
   assign poll_lim  = (cfg.ack_poll_limit == '0) ? 8'd1 : cfg.ack_poll_limit;
   assign clear_lim = (cfg.clear_pulses == '0) ? 4'd1 : cfg.clear_pulses;

   always_comb begin
      case (op)
         i2cm_pkg::OP_START,
         i2cm_pkg::OP_STOP,
         i2cm_pkg::OP_WRITE,
         i2cm_pkg::OP_READ,
         i2cm_pkg::OP_CLEAR: op_valid = 1'b1;
         default:            op_valid = 1'b0;
      endcase
   end

   always_comb begin
      op_in     = op_ff;
      step_in   = step_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      poll_in   = poll_ff;
      pins_in   = pins_ff;
      ack_in    = ack_ff;
      rx_in     = rx_ff;
      choice_in = choice_ff;
      done      = 1'b0;

      // command launch, only while idle
      if (op_ff == i2cm_pkg::OP_NONE && op_valid) begin
         op_in    = i2cm_pkg::op_type'(op);
         step_in  = '0;
         tick_in  = '0;
         bit_in   = '0;
         poll_in  = '0;
         shift_in = (op == i2cm_pkg::OP_WRITE) ? tx_byte : 8'd0;
         if (op == i2cm_pkg::OP_READ) begin
            choice_in = send_ack;
         end
      end

      if (op_in != i2cm_pkg::OP_NONE) begin
         // first tick of a segment: pin actions
         if (tick_in == '0) begin
            case (op_in)
               i2cm_pkg::OP_START: pins_in = start_pins(step_in, pins_in);
               i2cm_pkg::OP_STOP:  pins_in = stop_pins(step_in, pins_in);
               i2cm_pkg::OP_WRITE: begin
                  if (step_in == 4'd0) begin
                     pins_in.scl = 1'b0;
                     pins_in.sda = shift_in[7];
                     shift_in    = {shift_in[6:0], 1'b0};
                  end else if (step_in == 4'd1 || step_in == 4'd3) begin
                     pins_in.scl = 1'b1;
                  end else if (step_in == 4'd2) begin
                     pins_in.scl = 1'b0;
                     pins_in.sda = 1'b1;
                  end else begin
                     pins_in.scl = 1'b0;
                  end
               end
               i2cm_pkg::OP_READ: begin
                  if (step_in == 4'd0) begin
                     pins_in.scl = 1'b0;
                     pins_in.sda = 1'b1;
                  end else if (step_in == 4'd1 || step_in == 4'd3) begin
                     pins_in.scl = 1'b1;
                  end else if (step_in == 4'd2) begin
                     pins_in.scl = 1'b0;
                     pins_in.sda = ~choice_in;
                  end else begin
                     pins_in.scl = 1'b0;
                  end
               end
               default: begin
                  // bus clear: start, pulses, start, stop
                  if (step_in <= 4'd2) begin
                     pins_in = start_pins(step_in, pins_in);
                  end else if (step_in == 4'd3) begin
                     pins_in.scl = 1'b0;
                  end else if (step_in == 4'd4) begin
                     pins_in.scl = 1'b1;
                  end else if (step_in <= 4'd7) begin
                     pins_in = start_pins(step_in - 4'd5, pins_in);
                  end else begin
                     pins_in = stop_pins(step_in - 4'd8, pins_in);
                  end
               end
            endcase
         end

         tick_in = tick_in + 16'd1;

         // last tick of a segment: sample and advance
         if (tick_in >= hp) begin
            tick_in = '0;
            case (op_in)
               i2cm_pkg::OP_START,
               i2cm_pkg::OP_STOP: begin
                  if (step_in >= 4'd2) begin
                     done = 1'b1;
                  end else begin
                     step_in = step_in + 4'd1;
                  end
               end
               i2cm_pkg::OP_WRITE: begin
                  if (step_in == 4'd1) begin
                     bit_in  = bit_in + 4'd1;
                     step_in = (bit_in < 4'd8) ? 4'd0 : 4'd2;
                  end else if (step_in == 4'd3) begin
                     if (!sda_sample) begin
                        ack_in  = 1'b0;
                        step_in = 4'd4;
                     end else begin
                        poll_in = poll_in + 8'd1;
                        if (poll_in >= poll_lim) begin
                           ack_in  = 1'b1;
                           step_in = 4'd4;
                        end
                     end
                  end else if (step_in >= 4'd4) begin
                     done = 1'b1;
                  end else begin
                     step_in = step_in + 4'd1;
                  end
               end
               i2cm_pkg::OP_READ: begin
                  if (step_in == 4'd1) begin
                     shift_in = {shift_in[6:0], sda_sample};
                     bit_in   = bit_in + 4'd1;
                     step_in  = (bit_in < 4'd8) ? 4'd0 : 4'd2;
                  end else if (step_in >= 4'd4) begin
                     rx_in = shift_in;
                     done  = 1'b1;
                  end else begin
                     step_in = step_in + 4'd1;
                  end
               end
               default: begin
                  if (step_in == 4'd4) begin
                     bit_in  = bit_in + 4'd1;
                     step_in = (bit_in < clear_lim) ? 4'd3 : 4'd5;
                  end else if (step_in >= 4'd10) begin
                     done = 1'b1;
                  end else begin
                     step_in = step_in + 4'd1;
                  end
               end
            endcase
            if (done) begin
               op_in   = i2cm_pkg::OP_NONE;
               step_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff     <= i2cm_pkg::OP_NONE;
         step_ff   <= '0;
         tick_ff   <= '0;
         bit_ff    <= '0;
         shift_ff  <= '0;
         poll_ff   <= '0;
         pins_ff   <= '{scl: 1'b1, sda: 1'b1};
         ack_ff    <= 1'b0;
         rx_ff     <= '0;
         choice_ff <= 1'b0;
      end else if (advance) begin
         op_ff     <= op_in;
         step_ff   <= step_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         poll_ff   <= poll_in;
         pins_ff   <= pins_in;
         ack_ff    <= ack_in;
         rx_ff     <= rx_in;
         choice_ff <= choice_in;
      end
   end

   always_comb begin
      rsp.scl_out     = pins_in.scl;
      rsp.sda_out     = pins_in.sda;
      rsp.busy_res    = (op_in != i2cm_pkg::OP_NONE);
      rsp.done_res    = done;
      rsp.rx_byte     = rx_in;
      rsp.ack_missing = ack_in;
   end

   // idle engine holds step and tick at zero
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      op_ff == i2cm_pkg::OP_NONE |-> step_ff == '0 && tick_ff == '0)
      else $error("idle with nonzero step or tick");

   // a command only starts on an advanced tick
   a_launch_on_tick: assert property (@(posedge clock) disable iff (reset)
      op_ff != i2cm_pkg::OP_NONE && $past(op_ff) == i2cm_pkg::OP_NONE |-> $past(advance))
      else $error("command started without a tick");

   // state frozen while no tick arrives
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(op_ff) && $stable(step_ff) && $stable(tick_ff))
      else $error("sequencer moved without a tick");

   // step never runs past the end of bus clear
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 4'd10)
      else $error("sequence step out of range");

endmodule

FILE: src/i2c_master_byte_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// Byte-level I2C master: start, stop, write with ack polling, read with
// ack/nack, bus clear. Each request word is one timing tick.
//
//   port group  dir  handshake        word
//   req_*       in   valid/ready      op, tx_byte, send_ack, sda_in (one tick)
//   rsp_*       out  valid/ready      pins, busy, done, rx_byte, ack_missing
//   csr_*       in   write enable     index 0..2, 16-bit data
//
// One request word per clock when req_ready is high, answered next cycle.
// The sequencer state and the response register update together on accept.
// req_ready is high while the response register is empty or being taken.
// Reset clears the sequencer and restores register defaults at once.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_op,
   input  logic [7:0]                          req_tx_byte,
   input  logic                                req_send_ack,
   input  logic                                req_sda_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_scl_out,
   output logic                                rsp_sda_out,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [7:0]                          rsp_rx_byte,
   output logic                                rsp_ack_missing,
   input  logic                                csr_write_en,
   input  logic [i2cm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   i2cm_pkg::cfg_type cfg_ff;
   i2cm_pkg::rsp_type rsp_next;
   i2cm_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks <= i2cm_pkg::HALF_PERIOD_RESET;
         cfg_ff.ack_poll_limit    <= i2cm_pkg::POLL_LIMIT_RESET;
         cfg_ff.clear_pulses      <= i2cm_pkg::CLEAR_PULSE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            i2cm_pkg::CSR_HALF_PERIOD: cfg_ff.half_period_ticks <= csr_wdata;
            i2cm_pkg::CSR_POLL_LIMIT:  cfg_ff.ack_poll_limit    <= csr_wdata[7:0];
            i2cm_pkg::CSR_CLEAR_PULSE: cfg_ff.clear_pulses      <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   i2cm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .op         (req_op),
      .tx_byte    (req_tx_byte),
      .send_ack   (req_send_ack),
      .sda_sample (req_sda_in),
      .cfg        (cfg_ff),
      .rsp        (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_out     = rsp_ff.scl_out;
   assign rsp_sda_out     = rsp_ff.sda_out;
   assign rsp_busy_res    = rsp_ff.busy_res;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_rx_byte     = rsp_ff.rx_byte;
   assign rsp_ack_missing = rsp_ff.ack_missing;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C master byte engine. Every request word is
// one bus tick; a built-in tick predictor forecasts the pin, status and data
// word that each tick produces, and a checker compares every response word
// with the oldest forecast. Directed tests cover the register extremes, ack
// polling, read ack choice, bus clear and ignored commands; random I2C
// transactions follow under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;
   localparam logic [i2cm_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int RANDOM_WORDS = 250;
   localparam int LONG_TICKS = 100;
   localparam int CYCLE_LIMIT = 1000000;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [2:0]                       req_op = i2cm_pkg::OP_NONE;
   logic [7:0]                       req_tx_byte = 8'h00;
   logic                             req_send_ack = 1'b0;
   logic                             req_sda_in = 1'b1;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_scl_out;
   logic                             rsp_sda_out;
   logic                             rsp_busy_res;
   logic                             rsp_done_res;
   logic [7:0]                       rsp_rx_byte;
   logic                             rsp_ack_missing;
   logic                             csr_write_en = 1'b0;
   logic [i2cm_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [i2cm_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // tick predictor state
   i2cm_pkg::cfg_type cfg_q;
   i2cm_pkg::op_type  cur_cmd;
   logic [5:0]  seq_step;
   logic [15:0] seg_ticks;
   logic [3:0]  bit_cnt;
   logic [7:0]  shifter;
   logic [7:0]  poll_cnt;
   logic [7:0]  rx_last;
   logic        scl_q;
   logic        sda_q;
   logic        nack_q;
   logic        ack_drive;

   i2cm_pkg::rsp_type status_due[$];
   int          bad_words = 0;
   int          checked_words = 0;
   int          words_sent = 0;
   int          burst_left = 0;
   bit          full_rate = 1'b0;
   int          hold_request = 0;
   int          hold_left = 0;
   logic [15:0] ready_mask = 16'hFFFF;
   logic [3:0]  pat_pos = 4'd0;

   i2c_master_byte_engine_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_tx_byte     (req_tx_byte),
      .req_send_ack    (req_send_ack),
      .req_sda_in      (req_sda_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_scl_out     (rsp_scl_out),
      .rsp_sda_out     (rsp_sda_out),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_ack_missing (rsp_ack_missing),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void reset_model();
      cfg_q = {i2cm_pkg::HALF_PERIOD_RESET, i2cm_pkg::POLL_LIMIT_RESET,
               i2cm_pkg::CLEAR_PULSE_RESET};
      cur_cmd = i2cm_pkg::OP_NONE;
      seq_step = '0;
      seg_ticks = '0;
      bit_cnt = '0;
      shifter = '0;
      poll_cnt = '0;
      rx_last = '0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      nack_q = 1'b0;
      ack_drive = 1'b0;
   endfunction

   function automatic void start_cond(input int k);
      if (k == 0) scl_q = 1'b1;
      else if (k == 1) sda_q = 1'b0;
      else scl_q = 1'b0;
   endfunction

   function automatic void stop_cond(input int k);
      if (k == 0) begin
         scl_q = 1'b0;
      end else if (k == 1) begin
         sda_q = 1'b0;
         scl_q = 1'b1;
      end else begin
         sda_q = 1'b1;
      end
   endfunction

   // pin changes on the first tick of a segment
   function automatic void open_segment();
      int s;
      s = int'(seq_step);
      case (cur_cmd)
         i2cm_pkg::OP_START: start_cond(s);
         i2cm_pkg::OP_STOP: stop_cond(s);
         i2cm_pkg::OP_WRITE: begin
            if (s == 0) begin
               scl_q = 1'b0;
               sda_q = shifter[7];
               shifter = {shifter[6:0], 1'b0};
            end else if (s == 1 || s == 3) begin
               scl_q = 1'b1;
            end else if (s == 2) begin
               scl_q = 1'b0;
               sda_q = 1'b1;
            end else begin
               scl_q = 1'b0;
            end
         end
         i2cm_pkg::OP_READ: begin
            if (s == 0) begin
               scl_q = 1'b0;
               sda_q = 1'b1;
            end else if (s == 1 || s == 3) begin
               scl_q = 1'b1;
            end else if (s == 2) begin
               scl_q = 1'b0;
               sda_q = !ack_drive;
            end else begin
               scl_q = 1'b0;
            end
         end
         default: begin
            if (s <= 2) start_cond(s);
            else if (s == 3) scl_q = 1'b0;
            else if (s == 4) scl_q = 1'b1;
            else if (s <= 7) start_cond(s - 5);
            else stop_cond(s - 8);
         end
      endcase
   endfunction

   // sampling and sequencing on the last tick of a segment; 1 = command over
   function automatic bit close_segment(input logic sda);
      int s;
      int lim;
      s = int'(seq_step);
      close_segment = 1'b0;
      case (cur_cmd)
         i2cm_pkg::OP_START, i2cm_pkg::OP_STOP: begin
            if (s >= 2) close_segment = 1'b1;
            else seq_step = seq_step + 6'd1;
         end
         i2cm_pkg::OP_WRITE: begin
            if (s == 1) begin
               bit_cnt = bit_cnt + 4'd1;
               seq_step = (bit_cnt < 8) ? 6'd0 : 6'd2;
            end else if (s == 3) begin
               lim = (cfg_q.ack_poll_limit == 0) ? 1 : int'(cfg_q.ack_poll_limit);
               if (sda == 1'b0) begin
                  nack_q = 1'b0;
                  seq_step = 6'd4;
               end else begin
                  poll_cnt = poll_cnt + 8'd1;
                  if (poll_cnt >= lim) begin
                     nack_q = 1'b1;
                     seq_step = 6'd4;
                  end
               end
            end else if (s >= 4) begin
               close_segment = 1'b1;
            end else begin
               seq_step = seq_step + 6'd1;
            end
         end
         i2cm_pkg::OP_READ: begin
            if (s == 1) begin
               shifter = {shifter[6:0], sda};
               bit_cnt = bit_cnt + 4'd1;
               seq_step = (bit_cnt < 8) ? 6'd0 : 6'd2;
            end else if (s >= 4) begin
               rx_last = shifter;
               close_segment = 1'b1;
            end else begin
               seq_step = seq_step + 6'd1;
            end
         end
         default: begin
            if (s == 4) begin
               lim = (cfg_q.clear_pulses == 0) ? 1 : int'(cfg_q.clear_pulses);
               bit_cnt = bit_cnt + 4'd1;
               seq_step = (bit_cnt < lim) ? 6'd3 : 6'd5;
            end else if (s >= 10) begin
               close_segment = 1'b1;
            end else begin
               seq_step = seq_step + 6'd1;
            end
         end
      endcase
   endfunction

   function automatic i2cm_pkg::rsp_type bus_tick(input logic [2:0] op, input logic [7:0] tx,
                                                  input logic sack, input logic sda);
      int                hp;
      logic              done;
      i2cm_pkg::rsp_type r;
      hp = (cfg_q.half_period_ticks == 0) ? 1 : int'(cfg_q.half_period_ticks);
      done = 1'b0;
      if (cur_cmd == i2cm_pkg::OP_NONE && op >= i2cm_pkg::OP_START &&
          op <= i2cm_pkg::OP_CLEAR) begin
         cur_cmd = i2cm_pkg::op_type'(op);
         seq_step = '0;
         seg_ticks = '0;
         bit_cnt = '0;
         poll_cnt = '0;
         shifter = (cur_cmd == i2cm_pkg::OP_WRITE) ? tx : 8'h00;
         if (cur_cmd == i2cm_pkg::OP_READ) ack_drive = sack;
      end
      if (cur_cmd != i2cm_pkg::OP_NONE) begin
         if (seg_ticks == 0) open_segment();
         seg_ticks = seg_ticks + 16'd1;
         if (seg_ticks >= hp) begin
            seg_ticks = '0;
            if (close_segment(sda)) begin
               cur_cmd = i2cm_pkg::OP_NONE;
               seq_step = '0;
               done = 1'b1;
            end
         end
      end
      r.scl_out = scl_q;
      r.sda_out = sda_q;
      r.busy_res = (cur_cmd != i2cm_pkg::OP_NONE);
      r.done_res = done;
      r.rx_byte = rx_last;
      r.ack_missing = nack_q;
      return r;
   endfunction

   // one tick word; the sender runs in bursts with random gaps between some of them
   task automatic send_word(input logic [2:0] op, input logic [7:0] tx,
                            input logic sack, input logic sda);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (!full_rate && $urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= op;
      req_tx_byte <= tx;
      req_send_ack <= sack;
      req_sda_in <= sda;
      do @(posedge clock); while (req_ready !== 1'b1);
      status_due.push_back(bus_tick(op, tx, sack, sda));
      words_sent++;
   endtask

   function automatic logic pick_sda(input int low_pct);
      return ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
   endfunction

   // issue a command, then tick until the predictor says the engine is idle;
   // ops offered while busy must be ignored
   task automatic run_command(input logic [2:0] op, input logic [7:0] tx,
                              input logic sack, input int low_pct);
      logic [2:0] noise_op;
      send_word(op, tx, sack, pick_sda(low_pct));
      while (cur_cmd != i2cm_pkg::OP_NONE) begin
         noise_op = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                : i2cm_pkg::OP_NONE;
         send_word(noise_op, 8'($urandom), 1'($urandom), pick_sda(low_pct));
      end
   endtask

   task automatic put_reg(input logic [i2cm_pkg::CSR_INDEX_W-1:0] idx,
                          input logic [i2cm_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         i2cm_pkg::CSR_HALF_PERIOD: cfg_q.half_period_ticks = data;
         i2cm_pkg::CSR_POLL_LIMIT: cfg_q.ack_poll_limit = data[7:0];
         i2cm_pkg::CSR_CLEAR_PULSE: cfg_q.clear_pulses = data[3:0];
         default: ;
      endcase
   endtask

   // only with every response word taken
   task automatic set_timing(input logic [15:0] hp, input logic [7:0] poll,
                             input logic [3:0] pulses);
      logic [15:0] noise;
      noise = 16'($urandom);
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      put_reg(i2cm_pkg::CSR_HALF_PERIOD, hp);
      put_reg(i2cm_pkg::CSR_POLL_LIMIT, {noise[15:8], poll});
      put_reg(i2cm_pkg::CSR_CLEAR_PULSE, {noise[11:0], pulses});
      put_reg(CSR_SPARE, 16'($urandom));
      csr_write_en <= 1'b0;
   endtask

   task automatic test_reset_values();
      send_word(i2cm_pkg::OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
      send_word(OP_RSVD_6, 8'($urandom), 1'($urandom), 1'($urandom));
      send_word(OP_RSVD_7, 8'($urandom), 1'($urandom), 1'($urandom));
      run_command(i2cm_pkg::OP_START, 8'($urandom), 1'b0, 50);
      run_command(i2cm_pkg::OP_WRITE, 8'hA5, 1'b0, 100);
      run_command(i2cm_pkg::OP_READ, 8'($urandom), 1'b1, 50);
      run_command(i2cm_pkg::OP_STOP, 8'($urandom), 1'b0, 50);
   endtask

   task automatic test_ack_polling();
      set_timing(16'd1, 8'd1, 4'd9);
      run_command(i2cm_pkg::OP_START, 8'($urandom), 1'b0, 50);
      run_command(i2cm_pkg::OP_WRITE, 8'h00, 1'b0, 100);
      run_command(i2cm_pkg::OP_WRITE, 8'hFF, 1'b0, 0);
      set_timing(16'd2, 8'd255, 4'd9);
      run_command(i2cm_pkg::OP_WRITE, 8'h5A, 1'b0, 0);
      run_command(i2cm_pkg::OP_WRITE, 8'hC3, 1'b0, 10);
      set_timing(16'd1, 8'd0, 4'd9);
      run_command(i2cm_pkg::OP_WRITE, 8'h81, 1'b0, 0);
      run_command(i2cm_pkg::OP_STOP, 8'($urandom), 1'b0, 50);
   endtask

   task automatic test_read_ack();
      set_timing(16'd3, 8'd10, 4'd9);
      run_command(i2cm_pkg::OP_READ, 8'($urandom), 1'b0, 0);
      run_command(i2cm_pkg::OP_READ, 8'($urandom), 1'b1, 100);
      // SDA still held low by the ack when the start begins
      run_command(i2cm_pkg::OP_START, 8'($urandom), 1'b0, 50);
      run_command(i2cm_pkg::OP_READ, 8'($urandom), 1'b1, 50);
      run_command(i2cm_pkg::OP_STOP, 8'($urandom), 1'b0, 50);
   endtask

   task automatic test_bus_clear();
      set_timing(16'd1, 8'd10, 4'd15);
      run_command(i2cm_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 50);
      set_timing(16'd2, 8'd10, 4'd0);
      run_command(i2cm_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 50);
      set_timing(16'd1, 8'd10, 4'd1);
      run_command(i2cm_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 50);
   endtask

   task automatic test_zero_half_period();
      set_timing(16'd0, 8'd3, 4'd2);
      run_command(i2cm_pkg::OP_START, 8'($urandom), 1'b0, 50);
      run_command(i2cm_pkg::OP_WRITE, 8'h3C, 1'b0, 40);
      run_command(i2cm_pkg::OP_READ, 8'($urandom), 1'b0, 50);
      run_command(i2cm_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 50);
      run_command(i2cm_pkg::OP_STOP, 8'($urandom), 1'b0, 50);
   endtask

   // widest half period, then shortened while a segment is open
   task automatic test_long_half_period();
      set_timing(16'hFFFF, 8'd255, 4'd15);
      full_rate = 1'b1;
      send_word(i2cm_pkg::OP_START, 8'($urandom), 1'b0, 1'b1);
      repeat (LONG_TICKS)
         send_word(i2cm_pkg::OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
      full_rate = 1'b0;
      set_timing(16'd2, 8'd255, 4'd15);
      run_command(i2cm_pkg::OP_NONE, 8'($urandom), 1'b0, 50);
   endtask

   task automatic test_backpressure();
      set_timing(16'd1, 8'd4, 4'd3);
      hold_request = 300;
      run_command(i2cm_pkg::OP_START, 8'($urandom), 1'b0, 50);
      run_command(i2cm_pkg::OP_WRITE, 8'($urandom), 1'b0, 30);
      run_command(i2cm_pkg::OP_WRITE, 8'($urandom), 1'b0, 30);
      run_command(i2cm_pkg::OP_READ, 8'($urandom), 1'($urandom), 50);
      run_command(i2cm_pkg::OP_WRITE, 8'($urandom), 1'b0, 30);
      run_command(i2cm_pkg::OP_STOP, 8'($urandom), 1'b0, 50);
   endtask

   task automatic test_random_traffic();
      int first;
      int ack_pct;
      logic [15:0] hp;
      logic [7:0] poll;
      first = words_sent;
      while (words_sent - first < RANDOM_WORDS) begin
         case ($urandom_range(0, 19))
            0: hp = 16'd0;
            1: hp = 16'($urandom_range(4, 12));
            default: hp = 16'($urandom_range(1, 3));
         endcase
         case ($urandom_range(0, 9))
            0: poll = 8'd0;
            1: poll = 8'($urandom_range(13, 255));
            default: poll = 8'($urandom_range(1, 12));
         endcase
         set_timing(hp, poll, 4'($urandom_range(0, 15)));
         case ($urandom_range(0, 3))
            0: ack_pct = 100;
            1: ack_pct = 60;
            2: ack_pct = 20;
            default: ack_pct = 0;
         endcase
         repeat ($urandom_range(2, 5)) begin
            repeat ($urandom_range(0, 2))
               send_word(i2cm_pkg::OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
            if ($urandom_range(0, 4) != 0) begin
               run_command(i2cm_pkg::OP_START, 8'($urandom), 1'($urandom), 50);
               run_command(i2cm_pkg::OP_WRITE, 8'($urandom), 1'($urandom), ack_pct);
               repeat ($urandom_range(1, 3)) begin
                  if ($urandom_range(0, 5) == 0)
                     run_command(i2cm_pkg::OP_START, 8'($urandom), 1'($urandom), 50);
                  if ($urandom_range(0, 1) == 0)
                     run_command(i2cm_pkg::OP_WRITE, 8'($urandom), 1'($urandom),
                                 ack_pct);
                  else
                     run_command(i2cm_pkg::OP_READ, 8'($urandom), 1'($urandom), 50);
               end
               run_command(i2cm_pkg::OP_STOP, 8'($urandom), 1'($urandom), 50);
            end else begin
               run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                           ack_pct);
            end
         end
      end
   endtask

   // receiver: stall pattern refreshed once its 16-bit mask is used up, plus requested hold-offs
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (full_rate) begin
         rsp_ready <= 1'b1;
      end else begin
         if (pat_pos == 4'd0) begin
            case ($urandom_range(0, 3))
               0: ready_mask = 16'hFFFF;
               1: ready_mask = 16'($urandom);
               2: ready_mask = 16'($urandom | $urandom);
               default: ready_mask = 16'($urandom & $urandom);
            endcase
         end
         rsp_ready <= ready_mask[pat_pos];
         pat_pos = pat_pos + 4'd1;
      end
   end

   always @(posedge clock) begin
      i2cm_pkg::rsp_type got;
      i2cm_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got = {rsp_scl_out, rsp_sda_out, rsp_busy_res, rsp_done_res,
                rsp_rx_byte, rsp_ack_missing};
         if (status_due.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
               $display("unexpected response word %0d: scl=%b sda=%b busy=%b done=%b rx=%h nack=%b",
                        checked_words, got.scl_out, got.sda_out, got.busy_res,
                        got.done_res, got.rx_byte, got.ack_missing);
         end else begin
            want = status_due.pop_front();
            if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
                got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                got.rx_byte !== want.rx_byte || got.ack_missing !== want.ack_missing) begin
               bad_words++;
               if (bad_words <= 10) begin
                  $display("word %0d expected: scl=%b sda=%b busy=%b done=%b rx=%h nack=%b",
                           checked_words, want.scl_out, want.sda_out, want.busy_res,
                           want.done_res, want.rx_byte, want.ack_missing);
                  $display("word %0d actual:   scl=%b sda=%b busy=%b done=%b rx=%h nack=%b",
                           checked_words, got.scl_out, got.sda_out, got.busy_res,
                           got.done_res, got.rx_byte, got.ack_missing);
               end
            end
         end
         checked_words++;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      reset_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_ack_polling();
      test_read_ack();
      test_bus_clear();
      test_zero_half_period();
      test_long_half_period();
      test_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (bad_words == 0 && status_due.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
